// ===== design/pdq_pkg.sv =====
package pdq_pkg;

  localparam int unsigned DEPTH        = 8;
  localparam int unsigned DATA_WIDTH   = 32;
  localparam int unsigned VALUE_W      = 32;
  localparam int unsigned POSITION_W   = 4;
  localparam int unsigned ITEM_COUNT_W = 4;

  // Occupancy counter holds 0..DEPTH.
  localparam int unsigned COUNT_W = $clog2(DEPTH + 1);
  // Index of one cell.
  localparam int unsigned IDX_W   = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  // Common width for position/count compares.
  localparam int unsigned CMP_W   = (COUNT_W > POSITION_W) ? COUNT_W : POSITION_W;

  typedef enum logic [2:0] {
    FN_PUSH_BACK  = 3'd0,
    FN_PUSH_FRONT = 3'd1,
    FN_INSERT_AT  = 3'd2,
    FN_POP_BACK   = 3'd3,
    FN_POP_FRONT  = 3'd4,
    FN_DELETE_AT  = 3'd5,
    FN_CLEAR      = 3'd6,
    FN_QUERY      = 3'd7
  } func_e;

  typedef enum logic [1:0] {
    ST_OK     = 2'd0,
    ST_FULL   = 2'd1,
    ST_EMPTY  = 2'd2,
    ST_BADPOS = 2'd3
  } status_e;

  typedef logic [DATA_WIDTH-1:0] word_t;

  // Broadcast to every cell: shift direction, target position and new word.
  typedef struct packed {
    logic             ins;
    logic             del;
    logic [CMP_W-1:0] pos;
    word_t            data;
  } cell_cmd_t;

  // Keep the low DATA_WIDTH bits of a request word, zero-fill above.
  function automatic word_t value_to_word(input logic [VALUE_W-1:0] v);
    word_t w;
    for (int i = 0; i < DATA_WIDTH; i++) begin
      w[i] = (i < VALUE_W) ? v[i] : 1'b0;
    end
    return w;
  endfunction

  function automatic logic [VALUE_W-1:0] word_to_value(input word_t w);
    logic [VALUE_W-1:0] v;
    for (int i = 0; i < VALUE_W; i++) begin
      v[i] = (i < DATA_WIDTH) ? w[i] : 1'b0;
    end
    return v;
  endfunction

endpackage

// ===== design/pdq_req_if.sv =====
interface pdq_req_if;
  import pdq_pkg::*;

  logic                          valid;
  logic                          ready;
  logic [2:0]                    func;
  logic signed [VALUE_W-1:0]     value;
  logic [POSITION_W-1:0]         position;

  modport source (output valid, func, value, position, input ready);
  modport sink   (input valid, func, value, position, output ready);
endinterface

// ===== design/pdq_rsp_if.sv =====
interface pdq_rsp_if;
  import pdq_pkg::*;

  logic                          valid;
  logic                          ready;
  logic [1:0]                    status;
  logic [ITEM_COUNT_W-1:0]       item_count;
  logic signed [VALUE_W-1:0]     front_value;
  logic signed [VALUE_W-1:0]     back_value;

  modport source (output valid, status, item_count, front_value, back_value, input ready);
  modport sink   (input valid, status, item_count, front_value, back_value, output ready);
endinterface

// ===== design/pdq_cell.sv =====
module pdq_cell (
  input  logic                      clk_i,
  input  logic [pdq_pkg::CMP_W-1:0] idx_i,
  input  pdq_pkg::cell_cmd_t        cmd_i,
  input  pdq_pkg::word_t            left_i,   // neighbor toward the front
  input  pdq_pkg::word_t            right_i,  // neighbor toward the back
  output pdq_pkg::word_t            data_o
);
  import pdq_pkg::*;

  word_t data_q, data_d;

  always_comb begin
    data_d = data_q;
    if (cmd_i.ins) begin
      if (idx_i > cmd_i.pos) begin
        data_d = left_i;
      end else if (idx_i == cmd_i.pos) begin
        data_d = cmd_i.data;
      end
    end else if (cmd_i.del && (idx_i >= cmd_i.pos)) begin
      data_d = right_i;
    end
  end

  always_ff @(posedge clk_i) begin
    data_q <= data_d;
  end

  assign data_o = data_q;

endmodule

// ===== design/pdq_ctrl.sv =====
module pdq_ctrl (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           accept_i,
  input  logic [2:0]                     func_i,
  input  logic [pdq_pkg::POSITION_W-1:0] position_i,
  input  logic [pdq_pkg::VALUE_W-1:0]    value_i,
  output pdq_pkg::cell_cmd_t             cmd_o,
  output logic [pdq_pkg::COUNT_W-1:0]    count_o,
  output logic [1:0]                     status_o
);
  import pdq_pkg::*;

  logic [COUNT_W-1:0] count_q, count_d;
  status_e            status_q, status_d;
  func_e              func;
  logic [CMP_W-1:0]   cnt_ext, pos_ext, tgt;
  logic               is_ins, is_del, is_clr, full, empty, pos_bad;

  assign func    = func_e'(func_i);
  assign cnt_ext = CMP_W'(count_q);
  assign pos_ext = CMP_W'(position_i);
  assign full    = (count_q == COUNT_W'(DEPTH));
  assign empty   = (count_q == '0);

  // Operation decode: which way to shift and where.
  always_comb begin
    is_ins = 1'b0;
    is_del = 1'b0;
    is_clr = 1'b0;
    tgt    = pos_ext;
    case (func)
      FN_PUSH_BACK:  begin is_ins = 1'b1; tgt = cnt_ext; end
      FN_PUSH_FRONT: begin is_ins = 1'b1; tgt = '0;      end
      FN_INSERT_AT:  begin is_ins = 1'b1;                end
      FN_POP_BACK:   begin is_del = 1'b1; tgt = cnt_ext - 1'b1; end
      FN_POP_FRONT:  begin is_del = 1'b1; tgt = '0;      end
      FN_DELETE_AT:  begin is_del = 1'b1;                end
      FN_CLEAR:      begin is_clr = 1'b1;                end
      default:       ;
    endcase
  end

  // Full/empty checks take priority over the position check.
  always_comb begin
    pos_bad  = is_ins ? (tgt > cnt_ext) : (tgt >= cnt_ext);
    status_d = ST_OK;
    if (is_ins) begin
      status_d = full ? ST_FULL : (pos_bad ? ST_BADPOS : ST_OK);
    end else if (is_del) begin
      status_d = empty ? ST_EMPTY : (pos_bad ? ST_BADPOS : ST_OK);
    end
  end

  always_comb begin
    cmd_o.ins  = accept_i && is_ins && (status_d == ST_OK);
    cmd_o.del  = accept_i && is_del && (status_d == ST_OK);
    cmd_o.pos  = tgt;
    cmd_o.data = value_to_word(value_i);
  end

  always_comb begin
    count_d = count_q;
    if (accept_i) begin
      if (is_clr) begin
        count_d = '0;
      end else if (cmd_o.ins) begin
        count_d = count_q + 1'b1;
      end else if (cmd_o.del) begin
        count_d = count_q - 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q  <= '0;
      status_q <= ST_OK;
    end else begin
      count_q <= count_d;
      if (accept_i) begin
        status_q <= status_d;
      end
    end
  end

  assign count_o  = count_q;
  assign status_o = status_q;

  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= COUNT_W'(DEPTH))
    else $error("occupancy above depth");

  a_one_shift: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(cmd_o.ins && cmd_o.del))
    else $error("insert and delete in one cycle");

  a_ins_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.ins |=> (count_q == $past(count_q) + 1'b1) && (status_q == ST_OK))
    else $error("insert did not grow the list");

  a_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept_i && is_clr) |=> (count_q == '0))
    else $error("clear left items behind");

  a_reject_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept_i && (status_d != ST_OK)) |=> $stable(count_q))
    else $error("rejected request changed the count");

endmodule

// ===== design/positional_deque_unit.sv =====
// A result is presented in the cycle after its request is accepted.
// Throughput: one request per cycle while the response side takes results;
// every insert or delete, positional ones included, finishes in one shift of the cell row.
// Reset (rst_ni low, asynchronous): the list empties and no result is pending;
// cell contents are not cleared and are never shown until written.
module positional_deque_unit (
  input  logic       clk_i,
  input  logic       rst_ni,
  pdq_req_if.sink    req_i,
  pdq_rsp_if.source  rsp_o
);
  import pdq_pkg::*;

  // Output register control: a new request is taken whenever the previous
  // result has left or is leaving in this cycle.
  logic               rsp_valid_q, rsp_valid_d;
  logic               accept;

  // Cell row, cell 0 is the front of the list.
  word_t              cell_data [DEPTH];
  cell_cmd_t          cmd;
  logic [COUNT_W-1:0] count;
  logic [1:0]         status;
  logic [IDX_W-1:0]   back_idx;

  assign req_i.ready = !rsp_valid_q || rsp_o.ready;
  assign accept      = req_i.valid && req_i.ready;

  pdq_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .accept_i   (accept),
    .func_i     (req_i.func),
    .position_i (req_i.position),
    .value_i    (req_i.value),
    .cmd_o      (cmd),
    .count_o    (count),
    .status_o   (status)
  );

  // Each cell takes its left neighbor on insert, its right neighbor on delete; the row ends
  // are tied off to zero: the front end is never selected, the back end only refills a cell past the count.
  for (genvar g = 0; g < DEPTH; g++) begin : g_cell
    pdq_cell u_cell (
      .clk_i   (clk_i),
      .idx_i   (CMP_W'(g)),
      .cmd_i   (cmd),
      .left_i  ((g == 0) ? word_t'('0) : cell_data[(g == 0) ? 0 : g - 1]),
      .right_i ((g == DEPTH - 1) ? word_t'('0)
                                 : cell_data[(g == DEPTH - 1) ? g : g + 1]),
      .data_o  (cell_data[g])
    );
  end

  always_comb begin
    rsp_valid_d = rsp_valid_q;
    if (accept) begin
      rsp_valid_d = 1'b1;
    end else if (rsp_o.ready) begin
      rsp_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rsp_valid_q <= 1'b0;
    end else begin
      rsp_valid_q <= rsp_valid_d;
    end
  end

  // The cells only move on an accepted request, which also reloads the
  // result, so a pending result can be read straight off the row.
  assign back_idx = IDX_W'(count - 1'b1);

  assign rsp_o.valid       = rsp_valid_q;
  assign rsp_o.status      = status;
  assign rsp_o.item_count  = ITEM_COUNT_W'(count);
  assign rsp_o.front_value = (count == '0) ? '0 : word_to_value(cell_data[0]);
  assign rsp_o.back_value  = (count == '0) ? '0 : word_to_value(cell_data[back_idx]);

  a_rsp_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (rsp_valid_q && !rsp_o.ready) |-> !accept)
    else $error("request taken while result stalled");

  a_no_shift_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd.ins || cmd.del) |-> accept)
    else $error("cell row moved without a request");

  a_result_follows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> rsp_valid_q)
    else $error("accepted request produced no result");

endmodule

// ===== test/positional_deque_unit_tb.sv =====
module positional_deque_unit_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import pdq_pkg::*;

  // Random part size and the request counts where the idle phases change.
  localparam int RAND_OPS    = 825;
  localparam int PHASE_A_END = 283;
  localparam int PHASE_B_END = 566;
  // Long receiver hold-off, started in the no-idle phase so the sender keeps
  // offering and the block has to back-pressure its request side.
  localparam int HOLD_AT     = 640;
  localparam int HOLD_CYCLES = 40;
  localparam int DRAIN_CYCLES = 8;
  localparam int CYCLE_LIMIT = 60000;
  localparam int MAX_REPORTS = 10;

  // One request as the testbench sees it.
  typedef struct packed {
    func_e                    func;
    logic signed [VALUE_W-1:0] value;
    logic [POSITION_W-1:0]    position;
  } deque_op_t;

  // One response.
  typedef struct packed {
    status_e                   status;
    logic [ITEM_COUNT_W-1:0]   count;
    logic signed [VALUE_W-1:0] front;
    logic signed [VALUE_W-1:0] back;
  } deque_rsp_t;

  // Shadow of the list: cells in logical order, cell 0 at the front.
  typedef struct packed {
    logic [DEPTH-1:0][DATA_WIDTH-1:0] cells;
    logic [COUNT_W-1:0]               occ;
  } deque_t;

  logic clk;
  logic rst_n;

  pdq_req_if req ();
  pdq_rsp_if rsp ();

  positional_deque_unit dut (
    .clk_i  (clk),
    .rst_ni (rst_n),
    .req_i  (req),
    .rsp_o  (rsp)
  );

  always #2 clk = ~clk;

  // Stimulus list: directed rows first, then the random part. For directed
  // rows with fixed set, the response is typed in; all others come from
  // the list model below.
  deque_op_t  stim_ops[$];
  bit         dir_fixed[$];
  deque_rsp_t dir_rsp[$];

  deque_t     gen_shadow;   // tracks the list while the random part is built
  deque_t     golden;       // tracks the list as requests are accepted
  deque_rsp_t pending_rsp[$];

  int acc_count;            // accepted requests, updated with NBA
  int rsp_count;
  int fault_count;
  int send_idx;
  int tx_idle_pct;
  int rx_idle_pct;
  logic rx_hold;

  // Scratch for the checker process.
  deque_op_t  mon_op;
  deque_rsp_t mon_want;
  deque_t     mon_next;

  // List model: applies one operation, returns the response and the new list.
  function automatic deque_rsp_t deque_apply(input deque_t s_in, input deque_op_t op,
                                             output deque_t s_out);
    deque_t      s;
    deque_rsp_t  r;
    int unsigned occ;
    int unsigned at;
    status_e     st;
    logic [DATA_WIDTH-1:0] w;
    s   = s_in;
    occ = s.occ;
    st  = ST_OK;
    at  = 0;
    w   = DATA_WIDTH'($unsigned(op.value));
    case (op.func)
      FN_PUSH_BACK, FN_PUSH_FRONT, FN_INSERT_AT: begin
        if (op.func == FN_PUSH_BACK) at = occ;
        else if (op.func == FN_INSERT_AT) at = op.position;
        // full check wins over a bad position
        if (occ >= DEPTH) begin
          st = ST_FULL;
        end else if (at > occ) begin
          st = ST_BADPOS;
        end else begin
          for (int i = DEPTH - 1; i > 0; i--) begin
            if (i > at && i <= occ) s.cells[i] = s.cells[i-1];
          end
          s.cells[at] = w;
          occ++;
        end
      end
      FN_POP_BACK, FN_POP_FRONT, FN_DELETE_AT: begin
        // empty check wins over a bad position
        if (occ == 0) begin
          st = ST_EMPTY;
        end else begin
          if (op.func == FN_POP_BACK) at = occ - 1;
          else if (op.func == FN_DELETE_AT) at = op.position;
          if (at >= occ) begin
            st = ST_BADPOS;
          end else begin
            for (int i = 0; i < DEPTH - 1; i++) begin
              if (i >= at && i + 1 < occ) s.cells[i] = s.cells[i+1];
            end
            occ--;
          end
        end
      end
      FN_CLEAR: occ = 0;
      default: ;
    endcase
    s.occ    = COUNT_W'(occ);
    r.status = st;
    r.count  = ITEM_COUNT_W'(occ);
    r.front  = (occ == 0) ? '0 : VALUE_W'(s.cells[0]);
    r.back   = (occ == 0) ? '0 : VALUE_W'(s.cells[occ-1]);
    s_out    = s;
    return r;
  endfunction

  // Appends one request to the stimulus list and tracks it in gen_shadow.
  task automatic add_op(input func_e f, input logic [VALUE_W-1:0] v,
                        input logic [POSITION_W-1:0] p, input bit fixed,
                        input status_e st = ST_OK, input int cnt = 0,
                        input logic [VALUE_W-1:0] fr = '0,
                        input logic [VALUE_W-1:0] bk = '0);
    deque_op_t  op;
    deque_rsp_t r;
    deque_t     nxt;
    op.func     = f;
    op.value    = v;
    op.position = p;
    r = deque_apply(gen_shadow, op, nxt);
    gen_shadow = nxt;
    stim_ops.insert(stim_ops.size(), op);
    if (fixed) begin
      r = '{st, ITEM_COUNT_W'(cnt), fr, bk};
    end
    dir_fixed.insert(dir_fixed.size(), fixed);
    dir_rsp.insert(dir_rsp.size(), r);
  endtask

  // Idle rates by phase: sender 26 / receiver 45, then swapped, then none.
  always_comb begin
    if (acc_count < PHASE_A_END) begin
      tx_idle_pct = 26;
      rx_idle_pct = 45;
    end else if (acc_count < PHASE_B_END) begin
      tx_idle_pct = 45;
      rx_idle_pct = 26;
    end else begin
      tx_idle_pct = 0;
      rx_idle_pct = 0;
    end
  end

  // Request driver. Valid and payload hold until the request is taken.
  initial begin
    req.valid    = 1'b0;
    req.func     = FN_QUERY;
    req.value    = '0;
    req.position = '0;
    send_idx     = 0;
    forever begin
      @(posedge clk);
      if (rst_n) begin
        if (req.valid && req.ready) send_idx++;
        if (!req.valid || req.ready) begin
          if (send_idx < stim_ops.size() &&
              (rx_hold || $urandom_range(99) >= tx_idle_pct)) begin
            req.valid    <= 1'b1;
            req.func     <= stim_ops[send_idx].func;
            req.value    <= stim_ops[send_idx].value;
            req.position <= stim_ops[send_idx].position;
          end else begin
            req.valid <= 1'b0;
          end
        end
      end
    end
  end

  // Response ready, with random stalls and the long hold-off.
  initial begin
    rsp.ready = 1'b0;
    forever begin
      @(posedge clk);
      if (rst_n) rsp.ready <= !rx_hold && ($urandom_range(99) >= rx_idle_pct);
    end
  end

  // Long hold-off, counted here at the falling edge.
  initial begin
    rx_hold = 1'b0;
    @(negedge clk);
    while (acc_count < HOLD_AT) @(negedge clk);
    rx_hold <= 1'b1;
    repeat (HOLD_CYCLES) @(negedge clk);
    rx_hold <= 1'b0;
  end

  // Checker: compare each response with the oldest expectation, then model
  // the request taken at this edge (its response can only come later).
  always @(posedge clk) begin
    if (rst_n) begin
      if (rsp.valid && rsp.ready) begin
        if (pending_rsp.size() == 0) begin
          fault_count++;
          if (fault_count <= MAX_REPORTS)
            $display("response %0d with nothing expected: %0d/%0d/%h/%h",
                     rsp_count, rsp.status, rsp.item_count, rsp.front_value,
                     rsp.back_value);
        end else begin
          mon_want = pending_rsp[0];
          pending_rsp.delete(0);
          if (rsp.status !== mon_want.status || rsp.item_count !== mon_want.count ||
              rsp.front_value !== mon_want.front || rsp.back_value !== mon_want.back) begin
            fault_count++;
            if (fault_count <= MAX_REPORTS)
              $display("response %0d mismatch: expected %s/%0d/%h/%h got %0d/%0d/%h/%h",
                       rsp_count, mon_want.status.name(), mon_want.count, mon_want.front,
                       mon_want.back, rsp.status, rsp.item_count, rsp.front_value,
                       rsp.back_value);
          end
        end
        rsp_count++;
      end
      if (req.valid && req.ready) begin
        mon_op.func     = func_e'(req.func);
        mon_op.value    = req.value;
        mon_op.position = req.position;
        mon_want = deque_apply(golden, mon_op, mon_next);
        golden   = mon_next;
        if (acc_count < dir_fixed.size() && dir_fixed[acc_count]) mon_want = dir_rsp[acc_count];
        pending_rsp.insert(pending_rsp.size(), mon_want);
        acc_count <= acc_count + 1;
      end
    end
  end

  // Run watchdog.
  initial begin
    repeat (CYCLE_LIMIT) @(posedge clk);
    $display("Verification failed");
    $finish;
  end

  // Main sequence: build stimulus, reset, wait for everything to drain.
  initial begin
    int unsigned r;
    int unsigned mode;
    int unsigned add_pct;
    int unsigned occ;
    func_e       f;
    logic [VALUE_W-1:0]    v;
    logic [POSITION_W-1:0] p;

    clk         = 1'b0;
    rst_n       = 1'b0;
    acc_count   = 0;
    rsp_count   = 0;
    fault_count = 0;
    gen_shadow  = '0;
    golden      = '0;
    mode        = 0;
    add_pct     = 45;

    // Directed part: empty-list errors, extremes, insert at both ends,
    // bad positions, full-list errors, deletes, clear and query.
    add_op(FN_QUERY,      32'h0,         4'd0,  1, ST_OK,    0);
    add_op(FN_POP_BACK,   32'h0,         4'd0,  1, ST_EMPTY, 0);
    add_op(FN_POP_FRONT,  32'hFFFF_FFFF, 4'd15, 1, ST_EMPTY, 0);
    add_op(FN_DELETE_AT,  32'h0,         4'd0,  1, ST_EMPTY, 0);
    // empty check comes before the position check
    add_op(FN_DELETE_AT,  32'h0,         4'd15, 1, ST_EMPTY, 0);
    add_op(FN_INSERT_AT,  32'h1234_5678, 4'd1,  1, ST_BADPOS, 0);
    // insert at 0 on an empty list acts as a push
    add_op(FN_INSERT_AT,  32'h7FFF_FFFF, 4'd0,  1, ST_OK, 1, 32'h7FFF_FFFF, 32'h7FFF_FFFF);
    add_op(FN_PUSH_BACK,  32'h8000_0000, 4'd15, 1, ST_OK, 2, 32'h7FFF_FFFF, 32'h8000_0000);
    add_op(FN_PUSH_FRONT, 32'h0,         4'd0,  1, ST_OK, 3, 32'h0, 32'h8000_0000);
    // insert at the count acts as a push back
    add_op(FN_INSERT_AT,  32'h1,         4'd3,  1, ST_OK, 4, 32'h0, 32'h1);
    add_op(FN_INSERT_AT,  32'hFFFF_FFFF, 4'd2,  0);
    add_op(FN_INSERT_AT,  32'hDEAD_BEEF, 4'd15, 1, ST_BADPOS, 5, 32'h0, 32'h1);
    add_op(FN_PUSH_BACK,  32'h5,         4'd0,  0);
    add_op(FN_PUSH_FRONT, 32'h6,         4'd0,  0);
    add_op(FN_INSERT_AT,  32'h5555_5555, 4'd4,  0);
    // list is full from here
    add_op(FN_PUSH_BACK,  32'hAAAA_AAAA, 4'd0,  1, ST_FULL, 8, 32'h6, 32'h5);
    add_op(FN_PUSH_FRONT, 32'hAAAA_AAAA, 4'd0,  1, ST_FULL, 8, 32'h6, 32'h5);
    // full check comes before the position check
    add_op(FN_INSERT_AT,  32'hAAAA_AAAA, 4'd15, 1, ST_FULL, 8, 32'h6, 32'h5);
    add_op(FN_DELETE_AT,  32'h0,         4'd8,  1, ST_BADPOS, 8, 32'h6, 32'h5);
    add_op(FN_DELETE_AT,  32'h0,         4'd3,  0);
    add_op(FN_DELETE_AT,  32'h0,         4'd0,  0);
    add_op(FN_POP_BACK,   32'h0,         4'd0,  0);
    add_op(FN_POP_FRONT,  32'h0,         4'd0,  0);
    add_op(FN_CLEAR,      32'h7777_7777, 4'd9,  1, ST_OK, 0);
    add_op(FN_QUERY,      32'hFFFF_FFFF, 4'd15, 1, ST_OK, 0);

    // Random part: mostly in-range positions, bias toward filling or
    // draining in stretches so the count sweeps empty to full and back.
    for (int n = 0; n < RAND_OPS; n++) begin
      if (n % 40 == 0) begin
        mode = $urandom_range(2);
        add_pct = (mode == 0) ? 65 : (mode == 1) ? 25 : 45;
      end
      occ = gen_shadow.occ;
      r   = $urandom_range(99);
      if (r < 2) begin
        f = FN_CLEAR;
      end else if (r < 7) begin
        f = FN_QUERY;
      end else if ($urandom_range(99) < add_pct) begin
        case ($urandom_range(2))
          0:       f = FN_PUSH_BACK;
          1:       f = FN_PUSH_FRONT;
          default: f = FN_INSERT_AT;
        endcase
      end else begin
        case ($urandom_range(2))
          0:       f = FN_POP_BACK;
          1:       f = FN_POP_FRONT;
          default: f = FN_DELETE_AT;
        endcase
      end
      p = POSITION_W'($urandom_range(15));
      if ($urandom_range(99) < 85) begin
        if (f == FN_INSERT_AT) p = POSITION_W'($urandom_range(occ));
        else if (f == FN_DELETE_AT && occ > 0) p = POSITION_W'($urandom_range(occ - 1));
      end
      v = $urandom;
      if ($urandom_range(9) == 0) begin
        case ($urandom_range(3))
          0:       v = 32'h0;
          1:       v = 32'hFFFF_FFFF;
          2:       v = 32'h7FFF_FFFF;
          default: v = 32'h8000_0000;
        endcase
      end
      add_op(f, v, p, 0);
    end

    repeat (7) @(posedge clk);
    rst_n <= 1'b1;

    // Everything accepted and answered, then a drain wait for stray output.
    @(negedge clk);
    while (acc_count < stim_ops.size() || pending_rsp.size() != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);

    if (pending_rsp.size() != 0) begin
      $display("%0d expected responses never arrived", pending_rsp.size());
      fault_count += pending_rsp.size();
    end
    if (fault_count == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
